FILE: hw/rtl/dense_code_byte_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dense code byte decoder
// Shared forms of the concurrent checks used inside the decoder modules.
// ----------------------------------------------------------------------------
`ifndef DENSE_CODE_BYTE_DECODER_ASSERT_SVH
`define DENSE_CODE_BYTE_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCBD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/dcbd_pkg.sv
// ----------------------------------------------------------------------------
// Dense code byte decoder package
// Types and constants shared by the decoder front end, queues and back end.
// ----------------------------------------------------------------------------
package dcbd_pkg;

   // Boundary between continuer bytes and terminator bytes.
   localparam logic [7:0] TAG_BOUND = 8'd128;

   // Default vocabulary depth and queue depths.
   localparam int VOCAB_DEPTH_DEFAULT = 65536;
   localparam int WORK_DEPTH_DEFAULT  = 4;
   localparam int RESULT_DEPTH_DEFAULT = 4;

   // Widths fixed by the item fields.
   localparam int SYMBOL_W     = 32;
   localparam int RANK_W       = 32;
   localparam int CODE_W       = 8;
   localparam int INDEX_W      = 16;
   localparam int VOCAB_SIZE_W = 17;
   localparam int OP_W         = 2;

   // Command carried by an input item.
   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_DECODE = 1'b1
   } command_type;

   // Operation handed from the front end to the back end.
   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_ERROR  = 2'd2
   } work_op_type;

endpackage

FILE: hw/rtl/dcbd_fifo.sv
// ----------------------------------------------------------------------------
// Decoder queue
// Small register queue with full, empty and occupancy count; DEPTH >= 2.
// ----------------------------------------------------------------------------
module dcbd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/dcbd_front.sv
// ----------------------------------------------------------------------------
// Decoder front end
// Accepts items, keeps the running rank and classifies each item into a
// load, a lookup, an error or (continuer, bad load index) no operation.
// ----------------------------------------------------------------------------
module dcbd_front #(
   parameter int VOCAB_DEPTH = dcbd_pkg::VOCAB_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input items
   input  logic                                 req_push,
   output logic                                 req_full,
   input  dcbd_pkg::command_type                req_command,
   input  logic [dcbd_pkg::CODE_W-1:0]          req_code_byte,
   input  logic [dcbd_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic [dcbd_pkg::SYMBOL_W-1:0]        req_entry_symbol,
   // Configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dcbd_pkg::VOCAB_SIZE_W-1:0]    csr_vocab_size,
   // Work queue
   output logic                                 work_push,
   output dcbd_pkg::work_op_type                work_op,
   output logic [$clog2(VOCAB_DEPTH)-1:0]       work_addr,
   output logic [dcbd_pkg::SYMBOL_W-1:0]        work_data,
   input  logic                                 work_full
);

   localparam int ADDR_W = $clog2(VOCAB_DEPTH);
   localparam int RANK_W = dcbd_pkg::RANK_W;
   localparam logic [RANK_W-1:0] DEPTH_LIMIT = RANK_W'(VOCAB_DEPTH);

   logic [RANK_W-1:0]                 rank_ff, rank_in;
   logic [dcbd_pkg::VOCAB_SIZE_W-1:0] vocab_size_ff;
   logic [RANK_W-1:0]                 cont_sum;
   logic [RANK_W-1:0]                 end_rank;
   logic [RANK_W-1:0]                 index_wide;
   logic [dcbd_pkg::CODE_W-1:0]       tail_byte;
   logic                              accept;
   logic                              is_continuer;
   logic                              rank_bad;
   logic                              index_bad;

   assign csr_ready = 1'b1;
   assign req_full  = work_full;
   assign accept    = req_push && !work_full;

   // Rank arithmetic, all modulo 2^32.
   assign is_continuer = (req_code_byte < dcbd_pkg::TAG_BOUND);
   assign cont_sum     = rank_ff + RANK_W'(req_code_byte) + RANK_W'(1);
   assign tail_byte    = req_code_byte - dcbd_pkg::TAG_BOUND;
   assign end_rank     = rank_ff + RANK_W'(tail_byte);
   assign index_wide   = RANK_W'(req_entry_index);
   assign rank_bad     = (end_rank >= RANK_W'(vocab_size_ff)) || (end_rank >= DEPTH_LIMIT);
   assign index_bad    = (index_wide >= DEPTH_LIMIT);

   // Running rank: a continuer sets it to (rank + byte + 1) << 7, a terminator clears it.
   always_comb begin
      rank_in = rank_ff;
      if (accept && req_command == dcbd_pkg::CMD_DECODE) begin
         if (is_continuer) begin
            rank_in = {cont_sum[RANK_W-8:0], 7'b0};
         end else begin
            rank_in = '0;
         end
      end
   end

   // Classification of the accepted item into a back end operation.
   always_comb begin
      work_push = 1'b0;
      work_op   = dcbd_pkg::OP_LOAD;
      work_addr = index_wide[ADDR_W-1:0];
      work_data = req_entry_symbol;
      case (req_command)
         dcbd_pkg::CMD_LOAD: begin
            work_push = accept && !index_bad;
         end
         dcbd_pkg::CMD_DECODE: begin
            work_push = accept && !is_continuer;
            work_addr = end_rank[ADDR_W-1:0];
            work_op   = rank_bad ? dcbd_pkg::OP_ERROR : dcbd_pkg::OP_LOOKUP;
         end
         default: begin
            work_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff       <= '0;
         vocab_size_ff <= '0;
      end else begin
         rank_ff <= rank_in;
         if (csr_valid) begin
            vocab_size_ff <= csr_vocab_size;
         end
      end
   end

endmodule

FILE: hw/rtl/dcbd_back.sv
// ----------------------------------------------------------------------------
// Decoder back end
// Takes operations from the work queue, writes or reads the vocabulary
// memory and hands finished results to the result queue.
// ----------------------------------------------------------------------------
`include "dense_code_byte_decoder_assert.svh"

module dcbd_back #(
   parameter int VOCAB_DEPTH  = dcbd_pkg::VOCAB_DEPTH_DEFAULT,
   parameter int RESULT_DEPTH = dcbd_pkg::RESULT_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Work queue
   input  logic                                work_empty,
   output logic                                work_pop,
   input  dcbd_pkg::work_op_type               work_op,
   input  logic [$clog2(VOCAB_DEPTH)-1:0]      work_addr,
   input  logic [dcbd_pkg::SYMBOL_W-1:0]       work_data,
   // Result queue
   input  logic [$clog2(RESULT_DEPTH+1)-1:0]   result_count,
   output logic                                result_push,
   output logic [dcbd_pkg::SYMBOL_W-1:0]       result_symbol,
   output logic                                result_error
);

   localparam int SYMBOL_W = dcbd_pkg::SYMBOL_W;
   localparam int CNT_W    = $clog2(RESULT_DEPTH + 1);
   localparam logic [CNT_W:0] RESULT_LIMIT = (CNT_W + 1)'(RESULT_DEPTH);

   logic [SYMBOL_W-1:0] vocab_mem [VOCAB_DEPTH];
   logic [SYMBOL_W-1:0] read_data_ff;
   logic                stage_valid_ff, stage_valid_in;
   logic                stage_error_ff, stage_error_in;
   logic [CNT_W:0]      committed;
   logic                space_ok;
   logic                mem_write;
   logic                mem_read;

   // A result slot is reserved for the item held in the read stage.
   assign committed = (CNT_W + 1)'(result_count) + (CNT_W + 1)'(stage_valid_ff);
   assign space_ok  = (committed < RESULT_LIMIT);

   // Loads need no result slot; lookups and errors do.
   always_comb begin
      work_pop       = 1'b0;
      mem_write      = 1'b0;
      mem_read       = 1'b0;
      stage_valid_in = 1'b0;
      stage_error_in = 1'b0;
      case (work_op)
         dcbd_pkg::OP_LOAD: begin
            work_pop  = !work_empty;
            mem_write = !work_empty;
         end
         dcbd_pkg::OP_LOOKUP: begin
            work_pop       = !work_empty && space_ok;
            mem_read       = work_pop;
            stage_valid_in = work_pop;
         end
         dcbd_pkg::OP_ERROR: begin
            work_pop       = !work_empty && space_ok;
            stage_valid_in = work_pop;
            stage_error_in = 1'b1;
         end
         default: begin
            work_pop = !work_empty;
         end
      endcase
   end

   // Vocabulary memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_write) begin
         vocab_mem[work_addr] <= work_data;
      end
      if (mem_read) begin
         read_data_ff <= vocab_mem[work_addr];
      end
   end

   // Read stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         stage_error_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         stage_error_ff <= stage_error_in;
      end
   end

   // An error result carries a zero symbol.
   assign result_push   = stage_valid_ff;
   assign result_error  = stage_error_ff;
   assign result_symbol = stage_error_ff ? '0 : read_data_ff;

   `DCBD_ASSERT_NOW(a_result_slot, clock, reset, stage_valid_ff, (CNT_W + 1)'(result_count) < RESULT_LIMIT, "result queue overrun")
   `DCBD_ASSERT_NEXT(a_lookup_staged, clock, reset, work_pop && work_op == dcbd_pkg::OP_LOOKUP, stage_valid_ff && !stage_error_ff, "lookup lost in read stage")
   `DCBD_ASSERT_NEXT(a_load_silent, clock, reset, work_pop && work_op == dcbd_pkg::OP_LOAD, !stage_valid_ff, "load produced a result")
   `DCBD_ASSERT_NOW(a_stage_origin, clock, reset, stage_valid_ff, $past(work_pop), "result without a work item")

endmodule

FILE: hw/rtl/dense_code_byte_decoder.sv
// ----------------------------------------------------------------------------
// Dense code byte decoder
// Turns an End-Tagged Dense Code byte stream back into vocabulary words.
// ----------------------------------------------------------------------------
// The decoder takes one item per cycle while req_full is low, load or code
// byte alike, and gives out one result per cycle while results are being
// popped. That figure is set by the back end's single-port vocabulary memory,
// which serves one write or one read each cycle. A terminator's result passes
// the work queue, read stage and result queue. The vocabulary memory is not
// cleared after reset; every rank that is decoded must first be loaded. The
// vocabulary size register may be written only while the decoder is idle.
module dense_code_byte_decoder #(
   parameter int VOCAB_DEPTH  = dcbd_pkg::VOCAB_DEPTH_DEFAULT,
   parameter int WORK_DEPTH   = dcbd_pkg::WORK_DEPTH_DEFAULT,
   parameter int RESULT_DEPTH = dcbd_pkg::RESULT_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Input items
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_command,
   input  logic [dcbd_pkg::CODE_W-1:0]          req_code_byte,
   input  logic [dcbd_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic [dcbd_pkg::SYMBOL_W-1:0]        req_entry_symbol,
   // Result items
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [dcbd_pkg::SYMBOL_W-1:0]        rsp_symbol,
   output logic                                 rsp_code_too_large,
   // Configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dcbd_pkg::VOCAB_SIZE_W-1:0]    csr_vocab_size
);

   localparam int ADDR_W   = $clog2(VOCAB_DEPTH);
   localparam int SYMBOL_W = dcbd_pkg::SYMBOL_W;
   localparam int OP_W     = dcbd_pkg::OP_W;
   localparam int WORK_W   = OP_W + ADDR_W + SYMBOL_W;
   localparam int RES_W    = SYMBOL_W + 1;

   dcbd_pkg::work_op_type                 front_op;
   logic [ADDR_W-1:0]                     front_addr;
   logic [SYMBOL_W-1:0]                   front_data;
   logic                                  front_push;
   logic                                  work_full;
   logic                                  work_empty;
   logic                                  work_pop;
   logic [WORK_W-1:0]                     work_head;
   logic [$clog2(WORK_DEPTH+1)-1:0]       work_count;
   logic [$clog2(RESULT_DEPTH+1)-1:0]     result_count;
   logic                                  result_push;
   logic [SYMBOL_W-1:0]                   result_symbol;
   logic                                  result_error;
   logic                                  result_full;
   logic [RES_W-1:0]                      result_head;

   // Front end: rank tracking and classification.
   dcbd_front #(
      .VOCAB_DEPTH (VOCAB_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_command      (dcbd_pkg::command_type'(req_command)),
      .req_code_byte    (req_code_byte),
      .req_entry_index  (req_entry_index),
      .req_entry_symbol (req_entry_symbol),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_vocab_size   (csr_vocab_size),
      .work_push        (front_push),
      .work_op          (front_op),
      .work_addr        (front_addr),
      .work_data        (front_data),
      .work_full        (work_full)
   );

   // Work queue between front and back end.
   dcbd_fifo #(
      .WIDTH (WORK_W),
      .DEPTH (WORK_DEPTH)
   ) u_work_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data ({front_op, front_addr, front_data}),
      .full      (work_full),
      .pop       (work_pop),
      .pop_data  (work_head),
      .empty     (work_empty),
      .count     (work_count)
   );

   // Back end: vocabulary memory access.
   dcbd_back #(
      .VOCAB_DEPTH  (VOCAB_DEPTH),
      .RESULT_DEPTH (RESULT_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .work_empty    (work_empty),
      .work_pop      (work_pop),
      .work_op       (dcbd_pkg::work_op_type'(work_head[WORK_W-1 -: OP_W])),
      .work_addr     (work_head[SYMBOL_W +: ADDR_W]),
      .work_data     (work_head[SYMBOL_W-1:0]),
      .result_count  (result_count),
      .result_push   (result_push),
      .result_symbol (result_symbol),
      .result_error  (result_error)
   );

   // Result queue towards the consumer; the back end reserves its slots.
   dcbd_fifo #(
      .WIDTH (RES_W),
      .DEPTH (RESULT_DEPTH)
   ) u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data ({result_error, result_symbol}),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (result_head),
      .empty     (rsp_empty),
      .count     (result_count)
   );

   assign rsp_code_too_large = result_head[RES_W-1];
   assign rsp_symbol         = result_head[SYMBOL_W-1:0];

   `include "dense_code_byte_decoder_assert.svh"

   `DCBD_ASSERT_NOW(a_no_full_push, clock, reset, result_push, !result_full, "result pushed into a full queue")
   `DCBD_ASSERT_NOW(a_work_bound, clock, reset, work_pop, work_count != '0, "work popped from an empty queue")
   `DCBD_ASSERT_NEXT(a_error_zero, clock, reset, result_push && result_error && !rsp_pop && rsp_empty, !rsp_empty && rsp_code_too_large && rsp_symbol == '0, "error result not presented")

endmodule
